@@ design/tlik_pkg.sv @@
// Shared types, constants and the arctangent table of the arm solver.
`default_nettype none
package tlik_pkg;

	localparam int WORD_BITS    = 64;
	localparam int CV_BITS      = 48;
	localparam int LINK_BITS    = 22;
	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 30;
	localparam int CORDIC_STEPS = 28;
	localparam int NORM_STEPS   = 6;
	// normalized max(|x|,|y|) lies in [2^(NORM_MSB-1), 2^NORM_MSB)
	localparam int NORM_MSB     = 41;

	typedef logic [WORD_BITS-1:0]      word_t;
	typedef logic signed [CV_BITS-1:0] cv_t;
	typedef logic [LINK_BITS-1:0]      link_t;

	localparam link_t       LINK_RESET = 22'd65536;
	localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE      = 32'h4000_0000;
	localparam word_t       Q_ONE_SQ   = 64'h1000_0000_0000_0000;

	// register index codes, decoded from paddr[2]
	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	localparam logic [31:0] ARC_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

	typedef struct packed {
		word_t v;
		word_t res;
	} sqrt_t;

	typedef struct packed {
		word_t                mag;
		word_t                den;
		logic [DIV_STEPS-1:0] q;
		logic                 neg;
		logic                 clamp;
	} div_t;

	typedef struct packed {
		cv_t         x;
		cv_t         y;
		logic [31:0] z;
		logic        zero;
	} cordic_t;

	typedef struct packed {
		logic  br;
		logic  flag;
		word_t r2;
	} side_t;

endpackage
`default_nettype wire

@@ design/tlik_if.sv @@
// Request and result channel interfaces of the arm solver.
`default_nettype none
interface tlik_req_if #(parameter int COORD_BITS = 24) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] target_x;
	logic signed [COORD_BITS-1:0] target_y;
	logic                         elbow_branch;
	modport source (output valid, output target_x, output target_y, output elbow_branch,
		input ready);
	modport sink (input valid, input target_x, input target_y, input elbow_branch,
		output ready);
endinterface

interface tlik_rsp_if #(parameter int ANGLE_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] first_angle;
	logic signed [ANGLE_BITS-1:0] second_angle;
	logic                         out_of_reach;
	modport source (output valid, output first_angle, output second_angle,
		output out_of_reach, input ready);
	modport sink (input valid, input first_angle, input second_angle,
		input out_of_reach, output ready);
endinterface
`default_nettype wire

@@ design/tlik_sqrt_cell.sv @@
// One digit cell of the integer square root chain.
`default_nettype none
module tlik_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            en,
	input  tlik_pkg::sqrt_t d,
	output tlik_pkg::sqrt_t q
);
	import tlik_pkg::*;

	localparam word_t BIT = word_t'(1) << (62 - 2 * STEP);

	word_t trial;
	sqrt_t nxt;

	always_comb begin
		trial   = d.res + BIT;
		nxt.v   = d.v;
		nxt.res = d.res >> 1;
		if (d.v >= trial) begin
			nxt.v   = d.v - trial;
			nxt.res = (d.res >> 1) + BIT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

@@ design/tlik_div_cell.sv @@
// One quotient-bit cell of the restoring divider chain.
`default_nettype none
module tlik_div_cell (
	input  logic           clk,
	input  logic           en,
	input  tlik_pkg::div_t d,
	output tlik_pkg::div_t q
);
	import tlik_pkg::*;

	div_t nxt;

	always_comb begin
		nxt      = d;
		nxt.mag  = {d.mag[WORD_BITS-2:0], 1'b0};
		nxt.q    = {d.q[DIV_STEPS-2:0], 1'b0};
		if (nxt.mag >= d.den) begin
			nxt.mag  = nxt.mag - d.den;
			nxt.q[0] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

@@ design/tlik_cordic_cell.sv @@
// One vectoring rotation cell of the CORDIC chain.
`default_nettype none
module tlik_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  tlik_pkg::cordic_t d,
	output tlik_pkg::cordic_t q
);
	import tlik_pkg::*;

	cv_t     dx;
	cv_t     dy;
	cordic_t nxt;

	always_comb begin
		dx  = d.y >>> STEP;
		dy  = d.x >>> STEP;
		nxt = d;
		if (!d.y[CV_BITS-1]) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ARC_TAB[STEP];
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ARC_TAB[STEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

@@ design/tlik_vec.sv @@
// Vector angle unit: magnitude normalize, half-turn pre-rotate, CORDIC cell chain.
`default_nettype none
module tlik_vec (
	input  logic            clk,
	input  logic            en,
	input  tlik_pkg::word_t x_in,
	input  tlik_pkg::word_t y_in,
	output logic [31:0]     angle
);
	import tlik_pkg::*;

	typedef struct packed {
		logic  nx;
		logic  ny;
		word_t ax;
		word_t ay;
		word_t m;
	} norm_t;

	norm_t   nrm_q   [NORM_STEPS+1];
	norm_t   nrm_nxt [NORM_STEPS];
	norm_t   abs_d;
	cordic_t pre_d;
	cordic_t cq      [CORDIC_STEPS+1];
	word_t   xs;
	word_t   ys;

	always_comb begin
		abs_d.nx = x_in[WORD_BITS-1];
		abs_d.ny = y_in[WORD_BITS-1];
		abs_d.ax = abs_d.nx ? (~x_in + 1'b1) : x_in;
		abs_d.ay = abs_d.ny ? (~y_in + 1'b1) : y_in;
		abs_d.m  = (abs_d.ax > abs_d.ay) ? abs_d.ax : abs_d.ay;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_q[0] <= abs_d;
		end
	end

	// binary leading-zero search, largest shift first
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int    SH  = 32 >> j;
		localparam word_t LIM = word_t'(1) << (NORM_MSB - SH);
		always_comb begin
			nrm_nxt[j] = nrm_q[j];
			if (nrm_q[j].m < LIM) begin
				nrm_nxt[j].ax = nrm_q[j].ax << SH;
				nrm_nxt[j].ay = nrm_q[j].ay << SH;
				nrm_nxt[j].m  = nrm_q[j].m << SH;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				nrm_q[j+1] <= nrm_nxt[j];
			end
		end
	end

	always_comb begin
		xs         = nrm_q[NORM_STEPS].nx ? (~nrm_q[NORM_STEPS].ax + 1'b1) : nrm_q[NORM_STEPS].ax;
		ys         = nrm_q[NORM_STEPS].ny ? (~nrm_q[NORM_STEPS].ay + 1'b1) : nrm_q[NORM_STEPS].ay;
		pre_d.x    = cv_t'(xs[CV_BITS-1:0]);
		pre_d.y    = cv_t'(ys[CV_BITS-1:0]);
		pre_d.z    = '0;
		pre_d.zero = (nrm_q[NORM_STEPS].m == '0);
		if (pre_d.x < 0) begin
			pre_d.x = -pre_d.x;
			pre_d.y = -pre_d.y;
			pre_d.z = HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cq[0] <= pre_d;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		tlik_cordic_cell #(.STEP(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (cq[i]),
			.q   (cq[i+1])
		);
	end

	assign angle = cq[CORDIC_STEPS].zero ? 32'd0 : cq[CORDIC_STEPS].z;
endmodule
`default_nettype wire

@@ design/two_link_arm_inverse_kinematics.sv @@
// Two-link planar arm inverse kinematics: top level with config port and cell pipeline.
// Request accept loads s1; the last stage, s139, feeds the output queue.
// Throughput: one request per cycle while not stalled; every stage advances on a shared enable.
// The pipeline stalls only while the two-entry output queue is full and not drained.
// Reset (arst_n low, asynchronous): clears valid bits and queue; both link lengths read 65536.
`default_nettype none
module two_link_arm_inverse_kinematics #(
	parameter int COORD_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tlik_req_if.sink    req,
	tlik_rsp_if.source  rsp
);
	import tlik_pkg::*;

	// stage map: s1 input, s2 squares, s3 r^2, sqrt cells, s36 round r, s37 terms,
	// s38 divide setup, divider cells, s69 cosine, s70 square, s71 radicand,
	// sqrt cells, then the vector unit ends at the last stage
	localparam int VEC_LAT    = NORM_STEPS + 2 + CORDIC_STEPS;
	localparam int LAST_STAGE = 3 + SQRT_STEPS + 3 + DIV_STEPS + 3 + SQRT_STEPS + VEC_LAT;
	localparam int SIDE_LEN   = LAST_STAGE - 3;
	localparam int PH_LEN     = LAST_STAGE - (1 + VEC_LAT);
	localparam int CD_LEN     = SQRT_STEPS + 2;
	localparam int RES_BITS   = 2 * ANGLE_BITS + 1;
	localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);

	// ---------------- configuration registers ----------------
	link_t l1_q;
	link_t l2_q;
	logic  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= LINK_RESET;
			l2_q <= LINK_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_UPPER: begin
					l1_q <= pwdata[LINK_BITS-1:0];
				end
				REG_LOWER: begin
					l2_q <= pwdata[LINK_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_UPPER: begin
				prdata = {{(32-LINK_BITS){1'b0}}, l1_q};
			end
			REG_LOWER: begin
				prdata = {{(32-LINK_BITS){1'b0}}, l2_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// terms that depend on the link lengths only; the user must change config only while idle (not enforced here)
	logic [2*LINK_BITS-1:0] l1sq_q;
	logic [2*LINK_BITS-1:0] l2sq_q;
	logic [2*LINK_BITS:0]   l1l2x2_q;
	logic [2*LINK_BITS-1:0] dlsq_q;
	logic [2*LINK_BITS+1:0] slsq_q;
	logic                   lzero_q;
	link_t                  dl;
	logic [LINK_BITS:0]     sl;
	logic [2*LINK_BITS-1:0] l1l2;

	always_comb begin
		dl   = (l1_q > l2_q) ? (l1_q - l2_q) : (l2_q - l1_q);
		sl   = {1'b0, l1_q} + {1'b0, l2_q};
		l1l2 = l1_q * l2_q;
	end

	always_ff @(posedge clk) begin
		l1sq_q   <= l1_q * l1_q;
		l2sq_q   <= l2_q * l2_q;
		l1l2x2_q <= {l1l2, 1'b0};
		dlsq_q   <= dl * dl;
		slsq_q   <= sl * sl;
		lzero_q  <= (l1_q == '0) || (l2_q == '0);
	end

	// ---------------- flow control ----------------
	logic                en;
	logic                push;
	logic                pop;
	logic [1:0]          cnt_q;
	logic                wr_q;
	logic                rd_q;
	logic                vld_q [LAST_STAGE];
	logic [RES_BITS-1:0] buf_q [2];
	logic [RES_BITS-1:0] res_d;

	// advance every cell unless the queue is full and not being drained
	assign en        = (cnt_q != 2'd2) || rsp.ready;
	assign req.ready = en;
	assign push      = en && vld_q[LAST_STAGE-1];
	assign pop       = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAST_STAGE; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= req.valid;
			for (int k = 1; k < LAST_STAGE; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ---------------- s1..s3: square the radius ----------------
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic                         br_s1;
	logic                         br_s2;
	logic                         br_s3;
	logic [COORD_BITS-1:0]        ax;
	logic [COORD_BITS-1:0]        ay;
	logic [2*COORD_BITS-1:0]      sqx;
	logic [2*COORD_BITS-1:0]      sqy;
	word_t                        sqx_s2;
	word_t                        sqy_s2;
	word_t                        r2_s3;

	always_comb begin
		ax  = x_s1[COORD_BITS-1] ? (~x_s1 + 1'b1) : x_s1;
		ay  = y_s1[COORD_BITS-1] ? (~y_s1 + 1'b1) : y_s1;
		sqx = ax * ax;
		sqy = ay * ay;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= req.target_x;
			y_s1   <= req.target_y;
			br_s1  <= req.elbow_branch;
			sqx_s2 <= word_t'(sqx);
			sqy_s2 <= word_t'(sqy);
			br_s2  <= br_s1;
			r2_s3  <= sqx_s2 + sqy_s2;
			br_s3  <= br_s2;
		end
	end

	// phase unit runs alongside from s2
	logic [31:0] phase;
	logic [31:0] phd_q [PH_LEN];

	tlik_vec u_phase (
		.clk   (clk),
		.en    (en),
		.x_in  ({{(WORD_BITS-COORD_BITS){x_s1[COORD_BITS-1]}}, x_s1}),
		.y_in  ({{(WORD_BITS-COORD_BITS){y_s1[COORD_BITS-1]}}, y_s1}),
		.angle (phase)
	);

	// ---------------- sideband line: branch, reach flag, r^2 ----------------
	side_t side_q [SIDE_LEN];
	side_t side_d;

	always_comb begin
		side_d.br   = br_s3;
		side_d.r2   = r2_s3;
		side_d.flag = (r2_s3 == '0) || lzero_q || (r2_s3 < word_t'(dlsq_q)) ||
			(r2_s3 > word_t'(slsq_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_d;
			for (int k = 1; k < SIDE_LEN; k++) begin
				side_q[k] <= side_q[k-1];
			end
			phd_q[0] <= phase;
			for (int k = 1; k < PH_LEN; k++) begin
				phd_q[k] <= phd_q[k-1];
			end
		end
	end

	// ---------------- radius square root cells ----------------
	sqrt_t sq1 [SQRT_STEPS+1];

	assign sq1[0] = '{v: r2_s3, res: '0};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq1
		tlik_sqrt_cell #(.STEP(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq1[i]),
			.q   (sq1[i+1])
		);
	end

	// ---------------- s36..s38: round r, form ratio terms ----------------
	logic [32:0]          r_s36;
	logic                 r_up;
	logic [LINK_BITS+32:0] l1r;
	word_t                pos_s37 [2];
	word_t                neg_s37 [2];
	word_t                den_s37 [2];
	div_t                 div_s38 [2];
	div_t                 div_d   [2];
	word_t                r2_s36;

	assign r_up   = sq1[SQRT_STEPS].v > sq1[SQRT_STEPS].res;
	assign l1r    = l1_q * r_s36;
	assign r2_s36 = side_q[SQRT_STEPS].r2;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			div_d[i].neg   = pos_s37[i] < neg_s37[i];
			div_d[i].mag   = div_d[i].neg ? (neg_s37[i] - pos_s37[i]) :
				(pos_s37[i] - neg_s37[i]);
			div_d[i].den   = den_s37[i];
			div_d[i].q     = '0;
			div_d[i].clamp = (den_s37[i] == '0) || (div_d[i].mag >= den_s37[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s36      <= sq1[SQRT_STEPS].res[32:0] + {32'd0, r_up};
			pos_s37[0] <= word_t'(l1sq_q) + r2_s36;
			neg_s37[0] <= word_t'(l2sq_q);
			den_s37[0] <= word_t'({l1r, 1'b0});
			pos_s37[1] <= word_t'(l1sq_q) + word_t'(l2sq_q);
			neg_s37[1] <= r2_s36;
			den_s37[1] <= word_t'(l1l2x2_q);
			div_s38    <= div_d;
		end
	end

	// ---------------- divider cells, both ratios side by side ----------------
	div_t dv [2][DIV_STEPS+1];

	for (genvar n = 0; n < 2; n++) begin : g_div
		assign dv[n][0] = div_s38[n];
		for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
			tlik_div_cell u_cell (
				.clk (clk),
				.en  (en),
				.d   (dv[n][i]),
				.q   (dv[n][i+1])
			);
		end
	end

	// ---------------- s69..s71: cosine, sine radicand ----------------
	logic [1:0][31:0] c_s69;
	logic [1:0][31:0] c_d;
	logic [1:0][31:0] cd_q [CD_LEN];
	logic [61:0]      qq_s70  [2];
	logic [61:0]      qq_d    [2];
	word_t            rad_s71 [2];
	logic [31:0]      aq      [2];
	logic [31:0]      qv      [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qv[i] = {{(32-DIV_STEPS){1'b0}}, dv[i][DIV_STEPS].q};
			if (dv[i][DIV_STEPS].clamp) begin
				c_d[i] = dv[i][DIV_STEPS].neg ? (~Q_ONE + 1'b1) : Q_ONE;
			end else begin
				c_d[i] = dv[i][DIV_STEPS].neg ? (~qv[i] + 1'b1) : qv[i];
			end
			aq[i]   = c_s69[i][31] ? (~c_s69[i] + 1'b1) : c_s69[i];
			qq_d[i] = aq[i][30:0] * aq[i][30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s69    <= c_d;
			cd_q[0]  <= c_s69;
			for (int k = 1; k < CD_LEN; k++) begin
				cd_q[k] <= cd_q[k-1];
			end
			for (int i = 0; i < 2; i++) begin
				qq_s70[i]  <= qq_d[i];
				rad_s71[i] <= Q_ONE_SQ - word_t'(qq_s70[i]);
			end
		end
	end

	// ---------------- sine square root cells and arc-cosine vector units ----------------
	sqrt_t       sq2 [2][SQRT_STEPS+1];
	logic [31:0] acs [2];

	for (genvar n = 0; n < 2; n++) begin : g_acos
		assign sq2[n][0] = '{v: rad_s71[n], res: '0};
		for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
			tlik_sqrt_cell #(.STEP(i)) u_cell (
				.clk (clk),
				.en  (en),
				.d   (sq2[n][i]),
				.q   (sq2[n][i+1])
			);
		end
		tlik_vec u_vec (
			.clk   (clk),
			.en    (en),
			.x_in  ({{(WORD_BITS-32){cd_q[CD_LEN-1][n][31]}}, cd_q[CD_LEN-1][n]}),
			.y_in  (sq2[n][SQRT_STEPS].res),
			.angle (acs[n])
		);
	end

	// ---------------- joint angles, branch swap ----------------
	logic [31:0]           ang_a;
	logic [31:0]           ang_b;
	logic [31:0]           rnd_a;
	logic [31:0]           rnd_b;
	logic [ANGLE_BITS-1:0] out_a;
	logic [ANGLE_BITS-1:0] out_b;
	side_t                 side_end;

	assign side_end = side_q[SIDE_LEN-1];

	always_comb begin
		ang_a = phd_q[PH_LEN-1] + acs[0];
		ang_b = acs[1] + ang_a - HALF_TURN;
		rnd_a = ang_a + RND;
		rnd_b = ang_b + RND;
		out_a = rnd_a[31 -: ANGLE_BITS];
		out_b = rnd_b[31 -: ANGLE_BITS];
		if (side_end.br) begin
			res_d = {side_end.flag, out_b, out_a};
		end else begin
			res_d = {side_end.flag, out_a, out_b};
		end
	end

	// ---------------- two-entry output queue ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_d;
		end
	end

	assign rsp.valid        = cnt_q != 2'd0;
	assign rsp.out_of_reach = buf_q[rd_q][RES_BITS-1];
	assign rsp.first_angle  = buf_q[rd_q][2*ANGLE_BITS-1:ANGLE_BITS];
	assign rsp.second_angle = buf_q[rd_q][ANGLE_BITS-1:0];

`ifndef NO_ASSERTIONS
	// a result never lands in a full queue unless one leaves in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd2) |-> pop)
		else $error("output queue overflow");

	// a stalled pipeline holds its last stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q[LAST_STAGE-1]))
		else $error("pipeline moved while stalled");

	// requests are refused only while the queue is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (cnt_q == 2'd2))
		else $error("request refused with queue space");
`endif
endmodule
`default_nettype wire
